// ----- hdl/lsma_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lsma_pkg;

    localparam int MAP_WIDTH_DEF  = 256;
    localparam int MAP_HEIGHT_DEF = 256;

    localparam int CRD_ITER   = 16;
    localparam int CRD_STAGES = CRD_ITER / 2 + 2;
    localparam int CRD_W      = 34;

    localparam logic [15:0]        START_HEADING_RST   = 16'd0;
    localparam logic signed [15:0] HEADING_STEP_RST    = 16'sd182;
    localparam logic [15:0]        MIN_RANGE_RST       = 16'd123;
    localparam logic [15:0]        MAX_RANGE_RST       = 16'd3584;
    localparam logic signed [31:0] OFFSET_X_RST        = 32'sd0;
    localparam logic signed [31:0] OFFSET_Y_RST        = 32'sd0;
    localparam logic [15:0]        CELLS_PER_METER_RST = 16'd5120;
    localparam logic [6:0]         FREE_THRESHOLD_RST  = 7'd50;

    localparam logic signed [CRD_W-1:0] CRD_GAIN_INIT = 34'sd652032874;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_BEAM  = 1'b1;

    typedef enum logic [2:0] {
        CFG_START_HEADING   = 3'd0,
        CFG_HEADING_STEP    = 3'd1,
        CFG_MIN_RANGE       = 3'd2,
        CFG_MAX_RANGE       = 3'd3,
        CFG_OFFSET_X        = 3'd4,
        CFG_OFFSET_Y        = 3'd5,
        CFG_CELLS_PER_METER = 3'd6,
        CFG_FREE_THRESHOLD  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [CRD_W-1:0] z;
    } crd_t;

    typedef struct packed {
        logic        op;
        logic        keep;
        logic [15:0] beam_range;
        logic [15:0] cell_index;
        logic [7:0]  cell_value;
    } side_t;

    function automatic logic [31:0] atan_turn(input int unsigned i);
        logic [31:0] r;
        case (i)
            0:       r = 32'h20000000;
            1:       r = 32'h12E4051E;
            2:       r = 32'h09FB385B;
            3:       r = 32'h051111D4;
            4:       r = 32'h028B0D43;
            5:       r = 32'h0145D7E1;
            6:       r = 32'h00A2F61E;
            7:       r = 32'h00517C55;
            8:       r = 32'h0028BE53;
            9:       r = 32'h00145F2F;
            10:      r = 32'h000A2F98;
            11:      r = 32'h000517CC;
            12:      r = 32'h00028BE6;
            13:      r = 32'h000145F3;
            14:      r = 32'h0000A2F9;
            15:      r = 32'h0000517C;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic crd_t crd_rot(input crd_t a, input int unsigned i);
        crd_t r;
        logic signed [CRD_W-1:0] dx;
        logic signed [CRD_W-1:0] dy;
        logic signed [CRD_W-1:0] at;
        dx = a.y >>> i;
        dy = a.x >>> i;
        at = $signed({2'b00, atan_turn(i)});
        if (!a.z[CRD_W-1])
        begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - at;
        end
        else
        begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + at;
        end
        return r;
    endfunction

    function automatic logic signed [16:0] to_q15(input logic signed [CRD_W-1:0] v);
        logic signed [CRD_W-1:0] r;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767)
            return 17'sd32767;
        else if (r < -34'sd32768)
            return -17'sd32768;
        else
            return r[16:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/laser_scan_map_anomaly.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Lidar beam checker against a loaded occupancy map. Each word is either a
// map write (op 0) or a beam (op 1); exactly one result word leaves for each
// word taken, in order. One word is taken every cycle while in_stall is low:
// the path is a fully registered pipeline (heading and range test, a
// 16-step CORDIC at two steps a stage, projection, scaling, bounds, address,
// map memory read) with a valid bit per stage, so bubbles close up under
// out_stall. Map writes pass the same memory stage as reads, so a beam sees
// every earlier write. Configuration writes are taken at any time and must
// only be made while the pipeline is empty. Cells never written read back
// undefined.
module laser_scan_map_anomaly #(
    parameter int MAP_WIDTH  = lsma_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = lsma_pkg::MAP_HEIGHT_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                wr_en,
    input  wire  [2:0]         wr_index,
    input  wire  [31:0]        wr_data,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire                op,
    input  wire  [11:0]        beam_index,
    input  wire  [15:0]        beam_range,
    input  wire  [15:0]        cell_index,
    input  wire  signed [7:0]  cell_value,
    output logic               out_valid,
    input  wire                out_stall,
    output logic               in_range,
    output logic               in_map,
    output logic               anomaly,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic [7:0]         cell_x,
    output logic [7:0]         cell_y
);

    localparam int NCRD   = lsma_pkg::CRD_STAGES;
    localparam int S_IN   = 0;
    localparam int S_MUL  = S_IN + NCRD + 1;
    localparam int S_PNT  = S_MUL + 1;
    localparam int S_CMUL = S_PNT + 1;
    localparam int S_CELL = S_CMUL + 1;
    localparam int S_ADDR = S_CELL + 1;
    localparam int S_MEM  = S_ADDR + 1;
    localparam int S_OUT  = S_MEM + 1;
    localparam int NST    = S_OUT + 1;

    logic [15:0]        start_heading_reg;
    logic [15:0]        heading_step_reg;
    logic [15:0]        min_range_reg;
    logic [15:0]        max_range_reg;
    logic signed [31:0] offset_x_reg;
    logic signed [31:0] offset_y_reg;
    logic [15:0]        cells_per_meter_reg;
    logic [6:0]         free_threshold_reg;

    logic               v_reg    [0:NST-1];
    lsma_pkg::side_t    side_reg [0:S_MEM];
    logic [NST-1:0]     en;

    logic [15:0]        heading_reg;
    logic signed [16:0] cos_q;
    logic signed [16:0] sin_q;
    logic signed [33:0] prod_x_reg, prod_y_reg;
    logic signed [31:0] px_reg   [S_PNT:S_MEM];
    logic signed [31:0] py_reg   [S_PNT:S_MEM];
    logic signed [48:0] cprod_x_reg, cprod_y_reg;
    logic               in_map_reg [S_CELL:S_MEM];
    logic [15:0]        cx_reg, cy_reg;
    logic [7:0]         cx8_reg  [S_CELL:S_MEM];
    logic [7:0]         cy8_reg  [S_CELL:S_MEM];
    logic [15:0]        addr_reg;
    logic [7:0]         rdata_reg;
    logic [7:0]         map_mem [0:65535];

    logic               o_in_range_reg, o_in_map_reg, o_anomaly_reg;
    logic signed [31:0] o_px_reg, o_py_reg;
    logic [7:0]         o_cx_reg, o_cy_reg;

    logic [15:0]        heading_next;
    logic               keep_next;
    logic signed [31:0] px_next, py_next;
    logic signed [30:0] cx_next, cy_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_heading_reg   <= lsma_pkg::START_HEADING_RST;
            heading_step_reg    <= lsma_pkg::HEADING_STEP_RST;
            min_range_reg       <= lsma_pkg::MIN_RANGE_RST;
            max_range_reg       <= lsma_pkg::MAX_RANGE_RST;
            offset_x_reg        <= lsma_pkg::OFFSET_X_RST;
            offset_y_reg        <= lsma_pkg::OFFSET_Y_RST;
            cells_per_meter_reg <= lsma_pkg::CELLS_PER_METER_RST;
            free_threshold_reg  <= lsma_pkg::FREE_THRESHOLD_RST;
        end
        else if (wr_en)
        begin
            case (lsma_pkg::cfg_idx_t'(wr_index))
                lsma_pkg::CFG_START_HEADING:   start_heading_reg   <= wr_data[15:0];
                lsma_pkg::CFG_HEADING_STEP:    heading_step_reg    <= wr_data[15:0];
                lsma_pkg::CFG_MIN_RANGE:       min_range_reg       <= wr_data[15:0];
                lsma_pkg::CFG_MAX_RANGE:       max_range_reg       <= wr_data[15:0];
                lsma_pkg::CFG_OFFSET_X:        offset_x_reg        <= wr_data;
                lsma_pkg::CFG_OFFSET_Y:        offset_y_reg        <= wr_data;
                lsma_pkg::CFG_CELLS_PER_METER: cells_per_meter_reg <= wr_data[15:0];
                lsma_pkg::CFG_FREE_THRESHOLD:  free_threshold_reg  <= wr_data[6:0];
                default: ;
            endcase
        end
    end

    // advance a stage when it is empty or the one after it advances
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || !out_stall;
        for (int k = NST - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign in_stall = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    always_comb
    begin
        heading_next = start_heading_reg
                     + 16'(28'(beam_index) * 28'(heading_step_reg));
        keep_next    = (beam_range >= min_range_reg)
                    && (21'(beam_range) * 21'd20 <= 21'(max_range_reg) * 21'd19);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side_reg[0].op         <= op;
            side_reg[0].keep       <= keep_next;
            side_reg[0].beam_range <= beam_range;
            side_reg[0].cell_index <= cell_index;
            side_reg[0].cell_value <= cell_value;
            heading_reg            <= heading_next;
        end
        for (int k = 1; k <= S_MEM; k++)
            if (en[k])
                side_reg[k] <= side_reg[k-1];
    end

    lsma_cordic u_cordic (
        .clk     (clk),
        .en      (en[S_MUL-1:S_IN+1]),
        .heading (heading_reg),
        .cos_q   (cos_q),
        .sin_q   (sin_q)
    );

    function automatic logic signed [31:0] project(input logic signed [31:0] off,
                                                   input logic signed [33:0] prod);
        logic signed [33:0] t;
        logic signed [35:0] sum;
        t   = (prod + 34'sd16384) >>> 15;
        sum = 36'(off) + 36'(t);
        if (sum > 36'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (sum < -36'sd2147483648)
            return 32'sh80000000;
        else
            return sum[31:0];
    endfunction

    function automatic logic signed [30:0] trunc_cell(input logic signed [48:0] p);
        logic [48:0] mag;
        logic [30:0] q;
        mag = p[48] ? 49'(-p) : 49'(p);
        q   = 31'(mag >> 18);
        return p[48] ? $signed(-q) : $signed(q);
    endfunction

    function automatic logic in_bound(input logic signed [30:0] c, input int lim);
        return !c[30] && (c < 31'(lim));
    endfunction

    always_comb
    begin
        px_next = project(offset_x_reg, prod_x_reg);
        py_next = project(offset_y_reg, prod_y_reg);
        cx_next = trunc_cell(cprod_x_reg);
        cy_next = trunc_cell(cprod_y_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[S_MUL])
        begin
            prod_x_reg <= $signed({1'b0, side_reg[S_MUL-1].beam_range}) * cos_q;
            prod_y_reg <= $signed({1'b0, side_reg[S_MUL-1].beam_range}) * sin_q;
        end
        if (en[S_PNT])
        begin
            px_reg[S_PNT] <= px_next;
            py_reg[S_PNT] <= py_next;
        end
        for (int k = S_PNT + 1; k <= S_MEM; k++)
            if (en[k])
            begin
                px_reg[k] <= px_reg[k-1];
                py_reg[k] <= py_reg[k-1];
            end
        if (en[S_CMUL])
        begin
            cprod_x_reg <= px_reg[S_PNT] * $signed({1'b0, cells_per_meter_reg});
            cprod_y_reg <= py_reg[S_PNT] * $signed({1'b0, cells_per_meter_reg});
        end
        if (en[S_CELL])
        begin
            in_map_reg[S_CELL] <= in_bound(cx_next, MAP_WIDTH)
                               && in_bound(cy_next, MAP_HEIGHT);
            cx_reg             <= cx_next[15:0];
            cy_reg             <= cy_next[15:0];
            cx8_reg[S_CELL]    <= cx_next[7:0];
            cy8_reg[S_CELL]    <= cy_next[7:0];
        end
        for (int k = S_CELL + 1; k <= S_MEM; k++)
            if (en[k])
            begin
                in_map_reg[k] <= in_map_reg[k-1];
                cx8_reg[k]    <= cx8_reg[k-1];
                cy8_reg[k]    <= cy8_reg[k-1];
            end
        if (en[S_ADDR])
            addr_reg <= 16'(32'(cy_reg) * 32'(MAP_WIDTH) + 32'(cx_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en[S_MEM])
        begin
            if (v_reg[S_ADDR] && side_reg[S_ADDR].op == lsma_pkg::OP_WRITE)
                map_mem[side_reg[S_ADDR].cell_index] <= side_reg[S_ADDR].cell_value;
            rdata_reg <= map_mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
        begin
            o_in_range_reg <= 1'b0;
            o_in_map_reg   <= 1'b0;
            o_anomaly_reg  <= 1'b0;
            o_px_reg       <= '0;
            o_py_reg       <= '0;
            o_cx_reg       <= '0;
            o_cy_reg       <= '0;
            if (side_reg[S_MEM].op == lsma_pkg::OP_BEAM && side_reg[S_MEM].keep)
            begin
                o_in_range_reg <= 1'b1;
                o_px_reg       <= px_reg[S_MEM];
                o_py_reg       <= py_reg[S_MEM];
                if (in_map_reg[S_MEM])
                begin
                    o_in_map_reg  <= 1'b1;
                    o_anomaly_reg <= !rdata_reg[7] && (rdata_reg[6:0] < free_threshold_reg);
                    o_cx_reg      <= cx8_reg[S_MEM];
                    o_cy_reg      <= cy8_reg[S_MEM];
                end
            end
        end
    end

    assign out_valid = v_reg[S_OUT];
    assign in_range  = o_in_range_reg;
    assign in_map    = o_in_map_reg;
    assign anomaly   = o_anomaly_reg;
    assign point_x   = o_px_reg;
    assign point_y   = o_py_reg;
    assign cell_x    = o_cx_reg;
    assign cell_y    = o_cy_reg;

endmodule

`default_nettype wire

// ----- hdl/lsma_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lsma_cordic (
    input  wire                               clk,
    input  wire  [lsma_pkg::CRD_STAGES-1:0]   en,
    input  wire  [15:0]                       heading,
    output logic signed [16:0]                cos_q,
    output logic signed [16:0]                sin_q
);

    localparam int NROT = lsma_pkg::CRD_STAGES - 2;

    lsma_pkg::crd_t st_reg [0:NROT];
    logic           neg_reg [0:NROT];
    logic signed [16:0] cos_reg;
    logic signed [16:0] sin_reg;

    lsma_pkg::crd_t init_next;
    logic           neg_next;
    logic [15:0]    ang;

    always_comb
    begin
        ang      = heading;
        neg_next = 1'b0;
        if (heading >= 16'h4000 && heading < 16'hC000)
        begin
            ang      = heading - 16'h8000;
            neg_next = 1'b1;
        end
        init_next.x = lsma_pkg::CRD_GAIN_INIT;
        init_next.y = '0;
        init_next.z = $signed({{2{ang[15]}}, ang, 16'h0000});
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            st_reg[0]  <= init_next;
            neg_reg[0] <= neg_next;
        end
        for (int j = 1; j <= NROT; j++)
        begin
            if (en[j])
            begin
                st_reg[j]  <= lsma_pkg::crd_rot(lsma_pkg::crd_rot(st_reg[j-1],
                              unsigned'(2*(j-1))), unsigned'(2*(j-1)+1));
                neg_reg[j] <= neg_reg[j-1];
            end
        end
        if (en[NROT+1])
        begin
            cos_reg <= neg_reg[NROT] ? -lsma_pkg::to_q15(st_reg[NROT].x)
                                     :  lsma_pkg::to_q15(st_reg[NROT].x);
            sin_reg <= neg_reg[NROT] ? -lsma_pkg::to_q15(st_reg[NROT].y)
                                     :  lsma_pkg::to_q15(st_reg[NROT].y);
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

`default_nettype wire

// ----- hdl/lsma_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lsma_checker (
    input wire               clk,
    input wire               rst_n,
    input wire               out_valid,
    input wire               out_stall,
    input wire               in_range,
    input wire               in_map,
    input wire               anomaly,
    input wire signed [31:0] point_x,
    input wire signed [31:0] point_y,
    input wire [7:0]         cell_x,
    input wire [7:0]         cell_y
);

    // rejected beam or map write carries no point
    a_reject_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> !in_map && !anomaly && point_x == 0 && point_y == 0)
        else $error("rejected word carries data");

    // off-map hit carries no cell and no anomaly
    a_offmap_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_map |-> !anomaly && cell_x == 0 && cell_y == 0)
        else $error("off-map word carries cell");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(anomaly))
        else $error("stalled word changed");

endmodule

bind laser_scan_map_anomaly lsma_checker u_lsma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .in_range  (in_range),
    .in_map    (in_map),
    .anomaly   (anomaly),
    .point_x   (point_x),
    .point_y   (point_y),
    .cell_x    (cell_x),
    .cell_y    (cell_y)
);

`default_nettype wire

// ----- tb/laser_scan_map_anomaly_tb.sv -----
`timescale 1ns / 1ps

module laser_scan_map_anomaly_tb;

    typedef struct packed {
        bit               in_range;
        bit               in_map;
        bit               anomaly;
        bit signed [31:0] point_x;
        bit signed [31:0] point_y;
        bit [7:0]         cell_x;
        bit [7:0]         cell_y;
    } hit_result_t;

    class hit_scoreboard;
        byte         occupancy[65536];
        bit          written[65536];
        hit_result_t pending[$];
        int          errors;
        bit [15:0]   start_heading   = 16'd0;
        bit [15:0]   heading_step    = 16'd182;
        bit [15:0]   min_range       = 16'd123;
        bit [15:0]   max_range       = 16'd3584;
        longint      offset_x        = 0;
        longint      offset_y        = 0;
        bit [15:0]   cells_per_meter = 16'd5120;
        bit [6:0]    free_threshold  = 7'd50;
        longint      turn_atan[16] = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
            64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
            64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
            64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C};

        function longint round_q15(longint v);
            longint r;
            r = (v + 16384) >>> 15;
            if (r > 32767)
                r = 32767;
            if (r < -32768)
                r = -32768;
            return r;
        endfunction

        function void heading_trig(bit [15:0] ang, output longint c, output longint s);
            longint x, y, z, dx, dy;
            bit     flip;
            flip = 0;
            if (ang >= 16'h4000 && ang < 16'hC000)
            begin
                ang = ang - 16'h8000;
                flip = 1;
            end
            z = longint'($signed(ang)) * 65536;
            x = 652032874;
            y = 0;
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= turn_atan[i];
                end
                else
                begin
                    x += dx; y -= dy; z += turn_atan[i];
                end
            end
            c = round_q15(x);
            s = round_q15(y);
            if (flip)
            begin
                c = -c;
                s = -s;
            end
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint to_cell(longint p);
            longint prod;
            prod = p * longint'(cells_per_meter);
            if (prod >= 0)
                return prod >>> 18;
            return -((-prod) >>> 18);
        endfunction

        function hit_result_t project_beam(bit [11:0] idx, bit [15:0] rng);
            hit_result_t r;
            bit [15:0]   heading;
            longint      c, s, px, py, cx, cy;
            byte         v;
            r = '0;
            if (!(rng >= min_range && longint'(rng) * 20 <= longint'(max_range) * 19))
                return r;
            r.in_range = 1;
            heading = start_heading + 16'(idx * heading_step);
            heading_trig(heading, c, s);
            px = sat32(offset_x + ((longint'(rng) * c + 16384) >>> 15));
            py = sat32(offset_y + ((longint'(rng) * s + 16384) >>> 15));
            r.point_x = px[31:0];
            r.point_y = py[31:0];
            cx = to_cell(px);
            cy = to_cell(py);
            if (cx >= 0 && cx < 256 && cy >= 0 && cy < 256)
            begin
                r.in_map = 1;
                r.cell_x = cx[7:0];
                r.cell_y = cy[7:0];
                v = occupancy[{r.cell_y, r.cell_x}];
                r.anomaly = (v >= 0 && v < int'(free_threshold));
            end
            return r;
        endfunction

        function void queue_result(hit_result_t r);
            pending.insert(pending.size(), r);
        endfunction

        function void note_word(bit kind, bit [11:0] idx, bit [15:0] rng,
                                bit [15:0] addr, byte val);
            if (kind == lsma_pkg::OP_WRITE)
            begin
                occupancy[addr] = val;
                written[addr] = 1;
                queue_result('0);
            end
            else
                queue_result(project_beam(idx, rng));
        endfunction

        function void check_result(hit_result_t got);
            hit_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                $display("%0t: mismatch expected %p actual %p", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               wr_en;
    logic [2:0]         wr_index;
    logic [31:0]        wr_data;
    logic               in_valid;
    logic               in_stall;
    logic               op;
    logic [11:0]        beam_index;
    logic [15:0]        beam_range;
    logic [15:0]        cell_index;
    logic signed [7:0]  cell_value;
    logic               out_valid;
    logic               out_stall;
    logic               in_range;
    logic               in_map;
    logic               anomaly;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [7:0]         cell_x;
    logic [7:0]         cell_y;

    hit_scoreboard sb;
    int            burst_left;
    int            stall_mode;
    int            stall_left;
    longint        cycles;

    laser_scan_map_anomaly dut (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .beam_index(beam_index), .beam_range(beam_range),
        .cell_index(cell_index), .cell_value(cell_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .in_range(in_range), .in_map(in_map), .anomaly(anomaly),
        .point_x(point_x), .point_y(point_y), .cell_x(cell_x), .cell_y(cell_y)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 600000)
        begin
            $display("laser_scan_map_anomaly_tb: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result({in_range, in_map, anomaly, point_x, point_y, cell_x, cell_y});

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= $urandom_range(0, 1);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic send_word(bit kind, bit [11:0] idx, bit [15:0] rng,
                             bit [15:0] addr, byte val);
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                      : $urandom_range(1, 20);
        end
        in_valid   <= 1'b1;
        op         <= kind;
        beam_index <= idx;
        beam_range <= rng;
        cell_index <= addr;
        cell_value <= val;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(kind, idx, rng, addr, val);
        burst_left--;
    endtask

    task automatic send_beam_raw(bit [11:0] idx, bit [15:0] rng);
        send_word(lsma_pkg::OP_BEAM, idx, rng, $urandom, $urandom);
    endtask

    // write the target cell first if the beam would read an unwritten entry
    task automatic send_beam(bit [11:0] idx, bit [15:0] rng);
        hit_result_t r;
        r = sb.project_beam(idx, rng);
        if (r.in_map && !sb.written[{r.cell_y, r.cell_x}])
            send_word(lsma_pkg::OP_WRITE, $urandom, $urandom, {r.cell_y, r.cell_x},
                      ($urandom_range(0, 2) == 0) ? byte'($urandom) : byte'($urandom_range(0, 100)));
        send_beam_raw(idx, rng);
    endtask

    task automatic cfg_write(lsma_pkg::cfg_idx_t idx, bit [31:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        case (idx)
            lsma_pkg::CFG_START_HEADING:   sb.start_heading   = data[15:0];
            lsma_pkg::CFG_HEADING_STEP:    sb.heading_step    = data[15:0];
            lsma_pkg::CFG_MIN_RANGE:       sb.min_range       = data[15:0];
            lsma_pkg::CFG_MAX_RANGE:       sb.max_range       = data[15:0];
            lsma_pkg::CFG_OFFSET_X:        sb.offset_x        = longint'($signed(data));
            lsma_pkg::CFG_OFFSET_Y:        sb.offset_y        = longint'($signed(data));
            lsma_pkg::CFG_CELLS_PER_METER: sb.cells_per_meter = data[15:0];
            lsma_pkg::CFG_FREE_THRESHOLD:  sb.free_threshold  = data[6:0];
            default: ;
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // drop valid so the last word is not taken twice, then wait for the tail
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_phase(bit [15:0] sh, bit [15:0] st, bit [15:0] rmin, bit [15:0] rmax,
                             bit [31:0] ox, bit [31:0] oy, bit [15:0] cpm, bit [6:0] thr);
        drain();
        cfg_write(lsma_pkg::CFG_START_HEADING, sh);
        cfg_write(lsma_pkg::CFG_HEADING_STEP, st);
        cfg_write(lsma_pkg::CFG_MIN_RANGE, rmin);
        cfg_write(lsma_pkg::CFG_MAX_RANGE, rmax);
        cfg_write(lsma_pkg::CFG_OFFSET_X, ox);
        cfg_write(lsma_pkg::CFG_OFFSET_Y, oy);
        cfg_write(lsma_pkg::CFG_CELLS_PER_METER, cpm);
        cfg_write(lsma_pkg::CFG_FREE_THRESHOLD, thr);
    endtask

    task automatic random_words(int count);
        int lim;
        for (int n = 0; n < count; n++)
        begin
            lim = int'(sb.max_range) * 19 / 20;
            if ($urandom_range(0, 9) < 3)
                send_word(lsma_pkg::OP_WRITE, $urandom, $urandom, $urandom, $urandom);
            else if ($urandom_range(0, 9) < 8 && int'(sb.min_range) <= lim)
                send_beam($urandom, $urandom_range(sb.min_range, lim));
            else
                send_beam($urandom, $urandom);
        end
    endtask

    initial
    begin
        sb = new();
        clk = 0;
        rst_n = 0;
        wr_en = 0;
        wr_index = '0;
        wr_data = '0;
        in_valid = 0;
        op = lsma_pkg::OP_WRITE;
        beam_index = '0;
        beam_range = '0;
        cell_index = '0;
        cell_value = '0;
        out_stall = 0;
        burst_left = 0;
        stall_left = 0;
        cycles = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_word(lsma_pkg::OP_WRITE, 12'hFFF, 16'hFFFF, 16'h0000, -128);
        send_word(lsma_pkg::OP_WRITE, 12'h000, 16'h0000, 16'hFFFF, 127);
        send_beam(12'd0, 16'd0);
        send_beam(12'd0, 16'hFFFF);
        send_beam(12'd0, 16'd123);
        send_beam(12'd0, 16'd122);
        send_beam(12'd0, 16'd3404);
        send_beam(12'd0, 16'd3405);
        send_word(lsma_pkg::OP_WRITE, 12'd0, 16'd0, 16'h0000, 49);
        send_beam(12'd1000, 16'd200);
        send_beam(12'd4095, 16'd3000);
        send_word(lsma_pkg::OP_WRITE, 12'd0, 16'd0, 16'h0000, 50);
        send_beam(12'd1000, 16'd200);
        send_beam(12'd2048, 16'd150);

        set_phase($urandom, $urandom, 16'd0, 16'hFFFF, 32'd131072, 32'd131072,
                  16'd5120, 7'd127);
        send_beam(12'd0, 16'd0);
        send_beam(12'hFFF, 16'd62258);
        random_words(280);

        set_phase(16'hFFFF, 16'h8000, 16'd50, 16'd20000, 32'h7FFFFFFF, 32'h80000000,
                  16'hFFFF, 7'd0);
        random_words(200);

        set_phase($urandom, $urandom, 16'd0, 16'd60000, $urandom_range(0, 300000),
                  $urandom, 16'd0, 7'd1);
        random_words(250);

        set_phase($urandom, $urandom, 16'd1000, 16'd40000, $urandom_range(0, 262144),
                  $urandom_range(0, 262144), 16'd256, 7'd80);
        random_words(300);

        set_phase($urandom, 16'h7FFF, 16'd0, 16'd0, 32'd0, 32'd0, 16'd5120, 7'd50);
        send_beam(12'd7, 16'd0);
        random_words(120);

        set_phase($urandom, $urandom, $urandom_range(0, 300), $urandom_range(3000, 8000),
                  $urandom_range(60000, 200000), $urandom_range(60000, 200000),
                  $urandom_range(2000, 12000), $urandom_range(20, 100));
        random_words(400);

        @(negedge clk);
        in_valid <= 1'b0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("laser_scan_map_anomaly_tb: done, clean");
        else
            $display("laser_scan_map_anomaly_tb: done, errors");
        $finish;
    end

endmodule
